// ===== hw/rtl/bfs_pkg.sv =====
// shared constants for the 3x3 box filter stream
package bfs_pkg;

	localparam int PIX_W        = 8;
	localparam int COL_W        = 9;
	localparam int WIDTH_W      = 10;
	localparam int MAX_LINE_DEF = 512;

	localparam logic [WIDTH_W-1:0] LINE_WIDTH_RST = 10'd320;

endpackage

// ===== hw/rtl/bfs_line_mem.sv =====
// line store memory holding the two previous rows, one entry per column
module bfs_line_mem #(
	parameter int DEPTH = bfs_pkg::MAX_LINE_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                          clk,
	input  logic                          rd_en,
	input  logic [AW-1:0]                 rd_addr,
	output logic [2*bfs_pkg::PIX_W-1:0]   rd_data,
	input  logic                          wr_en,
	input  logic [AW-1:0]                 wr_addr,
	input  logic [2*bfs_pkg::PIX_W-1:0]   wr_data
);

	logic [2*bfs_pkg::PIX_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/bfs_window.sv =====
// 3x3 window registers, nine-pixel sum and divide by nine
module bfs_window (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       shift,
	input  logic [bfs_pkg::PIX_W-1:0]  top,
	input  logic [bfs_pkg::PIX_W-1:0]  mid,
	input  logic [bfs_pkg::PIX_W-1:0]  bot,
	output logic [bfs_pkg::PIX_W-1:0]  mean
);

	localparam int SUM_W = bfs_pkg::PIX_W + 4;
	localparam int REC_W = 13;
	localparam int PRD_W = SUM_W + REC_W;
	localparam logic [REC_W-1:0] RECIP = 13'd7282;

	logic [bfs_pkg::PIX_W-1:0] win_q [6];
	logic [SUM_W-1:0]          sum;
	logic [PRD_W-1:0]          prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (shift) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top;
			win_q[4] <= mid;
			win_q[5] <= bot;
		end
	end

	always_comb begin
		sum = SUM_W'(top) + SUM_W'(mid) + SUM_W'(bot);
		for (int i = 0; i < 6; i++) begin
			sum = sum + SUM_W'(win_q[i]);
		end
		// reciprocal of nine, exact for sums up to 2295
		prod = PRD_W'(sum) * PRD_W'(RECIP);
		mean = prod[16 +: bfs_pkg::PIX_W];
	end

endmodule

// ===== hw/rtl/box_filter_3x3_stream.sv =====
// top level of the 3x3 box filter stream
// path: an accepted pixel goes through stage s1, then into the output register
// throughput: one pixel per cycle unless in_stall; read on accept, write forwarding
// reset: counters, window and valid flags clear, line width returns to 320
// reset: line store contents stay undefined until written
module box_filter_3x3_stream #(
	parameter int MAX_LINE = bfs_pkg::MAX_LINE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [bfs_pkg::PIX_W-1:0]     pixel,
	input  logic                          frame_start,
	input  logic                          frame_end,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bfs_pkg::PIX_W-1:0]     mean_value,
	output logic [bfs_pkg::COL_W-1:0]     out_column,
	output logic                          last_of_frame,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bfs_pkg::WIDTH_W-1:0]   cfg_line_width
);

	localparam int AW = $clog2(MAX_LINE);
	localparam int CW = (AW + 1 > bfs_pkg::WIDTH_W) ? AW + 1 : bfs_pkg::WIDTH_W;
	localparam int PW = bfs_pkg::PIX_W;

	logic [bfs_pkg::WIDTH_W-1:0] width_q;
	logic [CW-1:0]               width_ext;
	logic [CW-1:0]               eff_width;
	logic [AW-1:0]               col_q;
	logic [1:0]                  row_q;
	logic [AW-1:0]               col_in;
	logic [1:0]                  row_in;
	logic [CW-1:0]               col_inc;
	logic                        acc;

	logic                        valid_s1;
	logic [PW-1:0]               px_s1;
	logic                        end_s1;
	logic                        emit_s1;
	logic [AW-1:0]               col_s1;
	logic                        hit_s1;
	logic [2*PW-1:0]             fwd_s1;
	logic                        move_s1;

	logic [2*PW-1:0]             mem_rd;
	logic [2*PW-1:0]             rd_eff;
	logic [2*PW-1:0]             wr_data;
	logic [PW-1:0]               mean;

	logic                        out_valid_q;
	logic [PW-1:0]               mean_q;
	logic [bfs_pkg::COL_W-1:0]   col_out_q;
	logic                        last_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= bfs_pkg::LINE_WIDTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			width_q <= cfg_line_width;
		end
	end

	always_comb begin
		width_ext = CW'(width_q);
		if (width_ext < CW'(3)) begin
			eff_width = CW'(3);
		end else if (width_ext > CW'(MAX_LINE)) begin
			eff_width = CW'(MAX_LINE);
		end else begin
			eff_width = width_ext;
		end
	end

	assign move_s1  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !move_s1;
	assign acc      = in_valid && !in_stall;

	assign col_in  = frame_start ? '0 : col_q;
	assign row_in  = frame_start ? 2'd0 : row_q;
	assign col_inc = CW'(col_in) + CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= 2'd0;
		end else if (acc) begin
			if (col_inc >= eff_width) begin
				col_q <= '0;
				row_q <= (row_in < 2'd2) ? row_in + 2'd1 : row_in;
			end else begin
				col_q <= col_inc[AW-1:0];
				row_q <= row_in;
			end
		end
	end

	// forward the line store write of the item leaving s1 to a same-column read
	assign rd_eff  = hit_s1 ? fwd_s1 : mem_rd;
	assign wr_data = {rd_eff[PW-1:0], px_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			px_s1   <= pixel;
			end_s1  <= frame_end;
			col_s1  <= col_in;
			emit_s1 <= (row_in == 2'd2) && (col_in >= AW'(2));
			hit_s1  <= move_s1 && (col_s1 == col_in);
			fwd_s1  <= wr_data;
		end
	end

	bfs_line_mem #(
		.DEPTH (MAX_LINE),
		.AW    (AW)
	) u_line_mem (
		.clk     (clk),
		.rd_en   (acc),
		.rd_addr (col_in),
		.rd_data (mem_rd),
		.wr_en   (move_s1),
		.wr_addr (col_s1),
		.wr_data (wr_data)
	);

	bfs_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (move_s1),
		.top    (rd_eff[2*PW-1:PW]),
		.mid    (rd_eff[PW-1:0]),
		.bot    (px_s1),
		.mean   (mean)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move_s1) begin
			out_valid_q <= emit_s1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1 && emit_s1) begin
			mean_q    <= mean;
			col_out_q <= bfs_pkg::COL_W'(col_s1 - AW'(2));
			last_q    <= end_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign mean_value    = mean_q;
	assign out_column    = col_out_q;
	assign last_of_frame = last_q;

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench for the 3x3 box filter stream, with a predicting scoreboard

typedef struct packed {
	logic [bfs_pkg::PIX_W-1:0] mean;
	logic [bfs_pkg::COL_W-1:0] column;
	logic                      last;
} box_mean_t;

class box_mean_scoreboard;
	logic [bfs_pkg::PIX_W-1:0]   row_minus2 [bfs_pkg::MAX_LINE_DEF];
	logic [bfs_pkg::PIX_W-1:0]   row_minus1 [bfs_pkg::MAX_LINE_DEF];
	logic [bfs_pkg::PIX_W-1:0]   window [6];
	logic [bfs_pkg::COL_W-1:0]   col_next;
	logic [1:0]                  rows_seen;
	logic [bfs_pkg::WIDTH_W-1:0] width_reg;
	box_mean_t                   pending_means [$];
	int unsigned                 mismatches;
	int unsigned                 pixels_seen;
	int unsigned                 results_seen;

	function new();
		for (int i = 0; i < bfs_pkg::MAX_LINE_DEF; i++) begin
			row_minus2[i] = '0;
			row_minus1[i] = '0;
		end
		for (int k = 0; k < 6; k++) window[k] = '0;
		col_next     = '0;
		rows_seen    = '0;
		width_reg    = bfs_pkg::LINE_WIDTH_RST;
		mismatches   = 0;
		pixels_seen  = 0;
		results_seen = 0;
	endfunction

	function void set_width(logic [bfs_pkg::WIDTH_W-1:0] w);
		width_reg = w;
	endfunction

	function logic [bfs_pkg::WIDTH_W-1:0] eff_width();
		if (width_reg < bfs_pkg::WIDTH_W'(3)) return bfs_pkg::WIDTH_W'(3);
		if (width_reg > bfs_pkg::WIDTH_W'(bfs_pkg::MAX_LINE_DEF))
			return bfs_pkg::WIDTH_W'(bfs_pkg::MAX_LINE_DEF);
		return width_reg;
	endfunction

	function int unsigned outstanding();
		return pending_means.size();
	endfunction

	function void take_pixel(logic [bfs_pkg::PIX_W-1:0] px, logic fs, logic fe);
		logic [bfs_pkg::COL_W-1:0] c;
		logic [bfs_pkg::PIX_W-1:0] top;
		logic [bfs_pkg::PIX_W-1:0] mid;
		logic [11:0]               total;
		box_mean_t                 r;
		pixels_seen++;
		if (fs) begin
			col_next  = '0;
			rows_seen = '0;
		end
		c   = col_next;
		top = row_minus2[c];
		mid = row_minus1[c];
		row_minus2[c] = mid;
		row_minus1[c] = px;
		if (rows_seen == 2'd2 && c >= 2) begin
			total = 12'(top) + 12'(mid) + 12'(px);
			for (int k = 0; k < 6; k++) total += 12'(window[k]);
			r.mean   = 8'(total / 12'd9);
			r.column = c - 9'd2;
			r.last   = fe;
			pending_means.push_back(r);
		end
		window[0] = window[3];
		window[1] = window[4];
		window[2] = window[5];
		window[3] = top;
		window[4] = mid;
		window[5] = px;
		if ({1'b0, c} + 10'd1 >= eff_width()) begin
			col_next = '0;
			if (rows_seen < 2'd2) rows_seen++;
		end else begin
			col_next = c + 9'd1;
		end
	endfunction

	function void match_result(logic [bfs_pkg::PIX_W-1:0] mean, logic [bfs_pkg::COL_W-1:0] column,
			logic last);
		box_mean_t want;
		results_seen++;
		if (pending_means.size() == 0) begin
			$error("unexpected result: mean_value %0d out_column %0d last_of_frame %0d",
				mean, column, last);
			mismatches++;
			return;
		end
		want = pending_means.pop_front();
		if (mean !== want.mean) begin
			$error("mean_value: expected %0d, actual %0d", want.mean, mean);
			mismatches++;
		end
		if (column !== want.column) begin
			$error("out_column: expected %0d, actual %0d", want.column, column);
			mismatches++;
		end
		if (last !== want.last) begin
			$error("last_of_frame: expected %0d, actual %0d", want.last, last);
			mismatches++;
		end
	endfunction
endclass

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PIX_W         = bfs_pkg::PIX_W;
	localparam int COL_W         = bfs_pkg::COL_W;
	localparam int WIDTH_W       = bfs_pkg::WIDTH_W;
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES   = 300;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [PIX_W-1:0]   pixel = '0;
	logic               frame_start = 1'b0;
	logic               frame_end = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [PIX_W-1:0]   mean_value;
	logic [COL_W-1:0]   out_column;
	logic               last_of_frame;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [WIDTH_W-1:0] cfg_line_width = '0;

	box_mean_scoreboard sb;
	int                 src_idle_pct = 0;
	int                 sink_stall_pct = 0;
	bit                 hold_pending = 1'b0;
	int                 width_writes = 0;

	box_filter_3x3_stream dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.pixel          (pixel),
		.frame_start    (frame_start),
		.frame_end      (frame_end),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.mean_value     (mean_value),
		.out_column     (out_column),
		.last_of_frame  (last_of_frame),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_line_width (cfg_line_width)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#6000000;
		$display("FAILURE");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) sb.set_width(cfg_line_width);
			if (in_valid && !in_stall) sb.take_pixel(pixel, frame_start, frame_end);
			if (out_valid && !out_stall) sb.match_result(mean_value, out_column, last_of_frame);
		end
	end

	// output side: random stalls, or one long hold-off on request
	initial begin
		forever begin
			if (hold_pending) begin
				hold_pending = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_stall <= ($urandom_range(99) < sink_stall_pct);
				@(posedge clk);
			end
		end
	end

	task automatic push_pixel(input logic [PIX_W-1:0] px, input logic fs, input logic fe);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		pixel       <= px;
		frame_start <= fs;
		frame_end   <= fe;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_width(input logic [WIDTH_W-1:0] w);
		cfg_valid      <= 1'b1;
		cfg_line_width <= w;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		width_writes++;
	endtask

	function automatic logic [PIX_W-1:0] rand_pixel();
		int r;
		r = $urandom_range(99);
		if (r < 10) return '0;
		if (r < 20) return '1;
		return PIX_W'($urandom_range(255));
	endfunction

	function automatic logic [WIDTH_W-1:0] pick_width();
		int r;
		r = $urandom_range(99);
		if (r < 10) return WIDTH_W'($urandom_range(0, 2));
		if (r < 20) return WIDTH_W'($urandom_range(13, 40));
		return WIDTH_W'($urandom_range(3, 12));
	endfunction

	task automatic send_run(input int n, input bit with_start, input bit with_end, input bit noisy);
		logic fs;
		logic fe;
		for (int i = 0; i < n; i++) begin
			fs = (with_start && i == 0) || (noisy && $urandom_range(15) == 0);
			fe = (with_end && i == n - 1) || (noisy && $urandom_range(7) == 0);
			push_pixel(rand_pixel(), fs, fe);
		end
	endtask

	task automatic run_directed();
		write_width(10'd5);
		// frame_end on a pixel that yields no result
		for (int i = 0; i < 10; i++) push_pixel(8'hFF, i == 0, i == 1);
		for (int i = 0; i < 4; i++) push_pixel(8'hFF, 1'b0, 1'b0);
		settle();
		// below minimum and narrower than the current column: row ends after next pixel
		write_width(10'd0);
		push_pixel(8'hFF, 1'b0, 1'b0);
		for (int i = 0; i < 3; i++) push_pixel(8'h00, 1'b0, i == 2);
		// next row with no frame_start
		for (int i = 0; i < 3; i++) push_pixel((i == 2) ? 8'h01 : 8'h80, 1'b0, 1'b0);
		settle();
	endtask

	task automatic random_phase(input int src_pct, input int snk_pct, input bit with_hold,
			input bit with_pause);
		int seg_items;
		int n;
		int kind;
		bit paused;
		src_idle_pct   = src_pct;
		sink_stall_pct = snk_pct;
		paused         = 1'b0;
		for (int s = 0; s < 3; s++) begin
			settle();
			write_width(pick_width());
			seg_items = 0;
			if (with_hold && s == 0) hold_pending = 1'b1;
			while (seg_items < 60) begin
				kind = $urandom_range(99);
				n    = $urandom_range(3, 6) * int'(sb.eff_width());
				if (seg_items == 0 || kind < 70) begin
					send_run(n, 1'b1, 1'b1, 1'b0);
				end else if (kind < 82) begin
					n = $urandom_range(1, n);
					send_run(n, 1'b1, 1'b1, 1'b0);
				end else if (kind < 92) begin
					send_run(n, 1'b0, 1'b1, 1'b0);
				end else begin
					send_run(n, 1'b1, 1'b0, 1'b1);
				end
				seg_items += n;
				if (with_pause && s == 1 && !paused) begin
					settle();
					paused = 1'b1;
				end
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		run_directed();
		random_phase(0, 0, 1'b1, 1'b0);
		random_phase(53, 0, 1'b0, 1'b1);
		random_phase(0, 53, 1'b0, 1'b0);
		random_phase(6, 6, 1'b0, 1'b0);
		settle();
		repeat (8) @(posedge clk);
		$display("run covered %0d pixels and %0d checked results over %0d line width settings",
			sb.pixels_seen, sb.results_seen, width_writes);
		$display("widths from below minimum up to forty, with idle, stall and hold-off phases");
		if (sb.mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule

// ===== files.f =====
hw/rtl/bfs_pkg.sv
hw/rtl/bfs_line_mem.sv
hw/rtl/bfs_window.sv
hw/rtl/box_filter_3x3_stream.sv
dv/tb_top.sv
